[hdl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with asynchronous reset disable
`define PPM_ASSERT(lbl, ck, rstn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);

// same cycle implication
`define PPM_ASSERT_IMPL(lbl, ck, rstn, ante, cons, msg) \
	`PPM_ASSERT(lbl, ck, rstn, (ante) |-> (cons), msg)

// next cycle implication
`define PPM_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
	`PPM_ASSERT(lbl, ck, rstn, (ante) |=> (cons), msg)

`endif

[hdl/ppm_pkg.sv]
`timescale 1ns / 1ps
package ppm_pkg;

	localparam int DEF_MAX_PEAKS = 16;

	localparam logic       RST_SAT_EN     = 1'b1;
	localparam logic [15:0] RST_SAT_COEFF = 16'd786;
	localparam logic [15:0] RST_GAIN      = 16'd3840;
	localparam logic [15:0] RST_PEDESTAL  = 16'd224;
	localparam logic [23:0] RST_CHARGE_MIN = 24'd172;
	localparam logic [15:0] RST_TIME_MIN  = 16'd16;
	localparam logic [15:0] RST_TIME_MAX  = 16'd16000;

	localparam logic [2:0] REG_SAT_EN     = 3'd0;
	localparam logic [2:0] REG_SAT_COEFF  = 3'd1;
	localparam logic [2:0] REG_GAIN       = 3'd2;
	localparam logic [2:0] REG_PEDESTAL   = 3'd3;
	localparam logic [2:0] REG_CHARGE_MIN = 3'd4;
	localparam logic [2:0] REG_TIME_MIN   = 3'd5;
	localparam logic [2:0] REG_TIME_MAX   = 3'd6;

	localparam logic [2:0] ST_NEW     = 3'd0;
	localparam logic [2:0] ST_MERGED  = 3'd1;
	localparam logic [2:0] ST_OUTSIDE = 3'd2;
	localparam logic [2:0] ST_FULL    = 3'd3;
	localparam logic [2:0] ST_DUMP    = 3'd4;
	localparam logic [2:0] ST_EMPTY   = 3'd5;

	localparam logic [1:0] KIND_ADD  = 2'd0;
	localparam logic [1:0] KIND_DUMP = 2'd1;
	localparam logic [1:0] KIND_OUT  = 2'd2;

	typedef struct packed {
		logic        sat_en;
		logic [15:0] sat_coeff;
		logic [15:0] gain;
		logic [15:0] pedestal;
		logic [23:0] charge_min;
		logic [15:0] time_min;
		logic [15:0] time_max;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] t;
		logic [23:0] q;
		logic [15:0] w;
	} item_t;

	function automatic logic overlap(input logic [15:0] ta, input logic [15:0] wa,
		input logic [15:0] tb, input logic [15:0] wb);
		logic [16:0] ea;
		logic [16:0] eb;
		ea = {1'b0, ta} + {1'b0, wa};
		eb = {1'b0, tb} + {1'b0, wb};
		return !(({1'b0, ta} > eb) || ({1'b0, tb} > ea));
	endfunction

	function automatic logic [23:0] sat_add24(input logic [23:0] a, input logic [23:0] b);
		logic [24:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[24] ? 24'hFFFFFF : s[23:0];
	endfunction

endpackage

[hdl/pulse_pileup_merge_table.sv]
`timescale 1ns / 1ps
// Pulse pile-up merge table. A request is taken when start is high and busy is low;
// busy stays high while the front end works on it: the hand-off alone for a dump or
// an out-of-window hit; a multiply, a 24-step radix-2 divider, a 3-stage width
// pipeline and the hand-off for a hit with saturation correction, the pipeline and
// hand-off without; plus any wait for room in the queue. A two-entry queue feeds
// the table sequencer, which reads (B_SRD) and checks (B_SCHK) each entry in turn;
// a merge runs B_MERGE, B_MWID, B_MWAIT and B_MWR (B_MERGE and B_MWR alone at zero
// gain), B_MVRD and B_MVWR if the last entry fills the hole, then a fresh scan; a
// dump reads out every entry. Results appear on result_valid for one cycle and
// cannot be held off, so the receiver must take each result in the cycle it shows.
module pulse_pileup_merge_table #(
	parameter int MAX_PEAKS = ppm_pkg::DEF_MAX_PEAKS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cmd,
	input  logic [15:0] hit_time,
	input  logic [23:0] hit_light,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [23:0] cfg_wdata,
	output logic        result_valid,
	output logic [2:0]  status,
	output logic [15:0] peak_time,
	output logic [23:0] peak_charge,
	output logic [15:0] peak_width,
	output logic [4:0]  peak_count,
	output logic        last
);
	import ppm_pkg::*;

	cfg_t  cfg_q;
	logic  q_full, q_not_empty, q_push, q_pop;
	item_t push_item, pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sat_en     <= RST_SAT_EN;
			cfg_q.sat_coeff  <= RST_SAT_COEFF;
			cfg_q.gain       <= RST_GAIN;
			cfg_q.pedestal   <= RST_PEDESTAL;
			cfg_q.charge_min <= RST_CHARGE_MIN;
			cfg_q.time_min   <= RST_TIME_MIN;
			cfg_q.time_max   <= RST_TIME_MAX;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_SAT_EN:     cfg_q.sat_en     <= cfg_wdata[0];
				REG_SAT_COEFF:  cfg_q.sat_coeff  <= cfg_wdata[15:0];
				REG_GAIN:       cfg_q.gain       <= cfg_wdata[15:0];
				REG_PEDESTAL:   cfg_q.pedestal   <= cfg_wdata[15:0];
				REG_CHARGE_MIN: cfg_q.charge_min <= cfg_wdata;
				REG_TIME_MIN:   cfg_q.time_min   <= cfg_wdata[15:0];
				REG_TIME_MAX:   cfg_q.time_max   <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	ppm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.start     (start),
		.cmd       (cmd),
		.hit_time  (hit_time),
		.hit_light (hit_light),
		.busy      (busy),
		.q_full    (q_full),
		.push      (q_push),
		.push_item (push_item)
	);

	ppm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.not_empty (q_not_empty),
		.pop       (q_pop),
		.pop_item  (pop_item)
	);

	ppm_back #(.MAX_PEAKS(MAX_PEAKS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_not_empty),
		.q_item       (pop_item),
		.pop          (q_pop),
		.result_valid (result_valid),
		.status       (status),
		.peak_time    (peak_time),
		.peak_charge  (peak_charge),
		.peak_width   (peak_width),
		.peak_count   (peak_count),
		.last         (last)
	);
endmodule

[hdl/ppm_ram.sv]
`timescale 1ns / 1ps
module ppm_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[hdl/ppm_width.sv]
`timescale 1ns / 1ps
module ppm_width (
	input  logic          clk,
	input  logic          arst_n,
	input  ppm_pkg::cfg_t cfg,
	input  logic          in_valid,
	input  logic [23:0]   q,
	output logic          out_valid,
	output logic [15:0]   w
);
	import ppm_pkg::*;

	logic        v_s1, v_s2, v_s3;
	logic [39:0] p_s1;
	logic        above_s1, sel_s2, ovf_s2;
	logic [28:0] lin_s2;
	logic [48:0] p2_s2;
	logic [15:0] w_s3;
	logic [16:0] ped16;

	assign ped16 = {1'b0, cfg.pedestal} + 17'd16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		p_s1     <= {16'd0, q} * {24'd0, cfg.gain};
		above_s1 <= q > cfg.charge_min;
		sel_s2   <= above_s1;
		lin_s2   <= {1'b0, p_s1[39:12]} + {13'd0, cfg.pedestal};
		ovf_s2   <= |p_s1[39:32];
		p2_s2    <= {17'd0, p_s1[31:0]} * {32'd0, ped16};
		if (sel_s2) begin
			w_s3 <= (|lin_s2[28:16]) ? 16'hFFFF : lin_s2[15:0];
		end else begin
			w_s3 <= (ovf_s2 || (|p2_s2[48:32])) ? 16'hFFFF : p2_s2[31:16];
		end
	end

	assign out_valid = v_s3;
	assign w         = w_s3;
endmodule

[hdl/ppm_front.sv]
`timescale 1ns / 1ps
module ppm_front (
	input  logic           clk,
	input  logic           arst_n,
	input  ppm_pkg::cfg_t  cfg,
	input  logic           start,
	input  logic           cmd,
	input  logic [15:0]    hit_time,
	input  logic [23:0]    hit_light,
	output logic           busy,
	input  logic           q_full,
	output logic           push,
	output ppm_pkg::item_t push_item
);
	import ppm_pkg::*;

	localparam logic [2:0] F_IDLE  = 3'd0;
	localparam logic [2:0] F_MUL   = 3'd1;
	localparam logic [2:0] F_DIV   = 3'd2;
	localparam logic [2:0] F_WID   = 3'd3;
	localparam logic [2:0] F_WWAIT = 3'd4;
	localparam logic [2:0] F_PUSH  = 3'd5;

	logic [2:0]  state_q;
	item_t       item_q;
	logic [40:0] den_q, rem_q;
	logic [23:0] quo_q;
	logic [4:0]  step_q;
	logic [41:0] rem2, diff;
	logic        ge;
	logic        wu_valid;
	logic [15:0] wu_w;

	// restoring divide, one quotient bit per cycle
	assign rem2 = {rem_q, 1'b0};
	assign ge   = rem2 >= {1'b0, den_q};
	assign diff = rem2 - {1'b0, den_q};

	ppm_width u_width (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (state_q == F_WID),
		.q         (item_q.q),
		.out_valid (wu_valid),
		.w         (wu_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: if (start) begin
					if (cmd) begin
						state_q <= F_PUSH;
					end else if (hit_time < cfg.time_min || hit_time > cfg.time_max) begin
						state_q <= F_PUSH;
					end else if (cfg.sat_en) begin
						state_q <= F_MUL;
					end else begin
						state_q <= F_WID;
					end
				end
				F_MUL:   state_q <= F_DIV;
				F_DIV:   if (step_q == 5'd23) state_q <= F_WID;
				F_WID:   state_q <= F_WWAIT;
				F_WWAIT: if (wu_valid) state_q <= F_PUSH;
				F_PUSH:  if (!q_full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: if (start) begin
				item_q.t <= hit_time;
				item_q.q <= hit_light;
				item_q.w <= 16'd0;
				if (cmd) begin
					item_q.kind <= KIND_DUMP;
				end else if (hit_time < cfg.time_min || hit_time > cfg.time_max) begin
					item_q.kind <= KIND_OUT;
				end else begin
					item_q.kind <= KIND_ADD;
				end
			end
			F_MUL: begin
				den_q  <= (41'd1 << 24) + ({25'd0, cfg.sat_coeff} * {17'd0, item_q.q});
				rem_q  <= {17'd0, item_q.q};
				quo_q  <= 24'd0;
				step_q <= 5'd0;
			end
			F_DIV: begin
				rem_q  <= ge ? diff[40:0] : rem2[40:0];
				quo_q  <= {quo_q[22:0], ge};
				step_q <= step_q + 5'd1;
				if (step_q == 5'd23) begin
					item_q.q <= {quo_q[22:0], ge};
				end
			end
			F_WWAIT: if (wu_valid) item_q.w <= wu_w;
			default: ;
		endcase
	end

	assign busy      = state_q != F_IDLE;
	assign push      = (state_q == F_PUSH) && !q_full;
	assign push_item = item_q;
endmodule

[hdl/ppm_queue.sv]
`timescale 1ns / 1ps
module ppm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ppm_pkg::item_t push_item,
	output logic           full,
	output logic           not_empty,
	input  logic           pop,
	output ppm_pkg::item_t pop_item
);
	import ppm_pkg::*;

	item_t      slot_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (pop) rptr_q <= !rptr_q;
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wptr_q] <= push_item;
	end

	assign full      = fill_q == 2'd2;
	assign not_empty = fill_q != 2'd0;
	assign pop_item  = slot_q[rptr_q];
endmodule

[hdl/ppm_back.sv]
`timescale 1ns / 1ps
module ppm_back #(
	parameter int MAX_PEAKS = ppm_pkg::DEF_MAX_PEAKS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ppm_pkg::cfg_t  cfg,
	input  logic           q_valid,
	input  ppm_pkg::item_t q_item,
	output logic           pop,
	output logic           result_valid,
	output logic [2:0]     status,
	output logic [15:0]    peak_time,
	output logic [23:0]    peak_charge,
	output logic [15:0]    peak_width,
	output logic [4:0]     peak_count,
	output logic           last
);
	import ppm_pkg::*;

	localparam int IDX_W = $clog2(MAX_PEAKS);
	localparam int CNT_W = $clog2(MAX_PEAKS + 1);

	localparam logic [3:0] B_IDLE  = 4'd0;
	localparam logic [3:0] B_SRD   = 4'd1;
	localparam logic [3:0] B_SCHK  = 4'd2;
	localparam logic [3:0] B_MERGE = 4'd3;
	localparam logic [3:0] B_MWID  = 4'd4;
	localparam logic [3:0] B_MWAIT = 4'd5;
	localparam logic [3:0] B_MWR   = 4'd6;
	localparam logic [3:0] B_MVRD  = 4'd7;
	localparam logic [3:0] B_MVWR  = 4'd8;
	localparam logic [3:0] B_END   = 4'd9;
	localparam logic [3:0] B_DRD   = 4'd10;
	localparam logic [3:0] B_DOUT  = 4'd11;

	logic [3:0]       state_q;
	logic [CNT_W-1:0] cnt_q, cnt_m1, cnt_p1;
	logic [IDX_W-1:0] scan_q, idx_q, other_q, last_ix;
	logic             first_q;
	item_t            it_q;
	logic [15:0]      cur_t_q, cur_w_q, ma_t_q, ma_w_q, mb_t_q;
	logic [23:0]      cur_q_q, ma_q_q, mb_q_q;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	logic [55:0]      ram_wdata, ram_rdata;
	logic [15:0]      rd_t, rd_w;
	logic [23:0]      rd_q;
	logic             scan_last, hit, table_full;
	logic             wu_valid;
	logic [15:0]      wu_w;
	logic             rv_set;

	logic             rv_q, last_q;
	logic [2:0]       st_q;
	logic [15:0]      pt_q, pw_q;
	logic [23:0]      pq_q;
	logic [CNT_W-1:0] pc_q;

	assign cnt_m1     = cnt_q - CNT_W'(1);
	assign cnt_p1     = cnt_q + CNT_W'(1);
	assign last_ix    = cnt_m1[IDX_W-1:0];
	assign scan_last  = CNT_W'(scan_q) == cnt_m1;
	assign table_full = cnt_q == CNT_W'(MAX_PEAKS);
	assign rd_t       = ram_rdata[55:40];
	assign rd_q       = ram_rdata[39:16];
	assign rd_w       = ram_rdata[15:0];

	// first pass tests against the request, later passes against the grown peak
	assign hit = first_q ? overlap(rd_t, rd_w, it_q.t, it_q.w)
		: ((scan_q != idx_q) && overlap(rd_t, rd_w, cur_t_q, cur_w_q));

	assign pop = (state_q == B_IDLE) && q_valid;

	// one-result requests answer straight from idle
	assign rv_set = ((state_q == B_IDLE) && q_valid && ((q_item.kind == KIND_OUT)
		|| ((q_item.kind == KIND_DUMP) && (cnt_q == '0))))
		|| (state_q == B_END) || (state_q == B_DOUT);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = {cur_t_q, cur_q_q, cur_w_q};
		ram_raddr = (state_q == B_MVRD) ? last_ix : scan_q;
		case (state_q)
			B_MWR: ram_we = 1'b1;
			B_MVWR: begin
				ram_we    = 1'b1;
				ram_waddr = other_q;
				ram_wdata = ram_rdata;
			end
			B_END: if (first_q && !table_full) begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q[IDX_W-1:0];
				ram_wdata = {it_q.t, it_q.q, it_q.w};
			end
			default: ;
		endcase
	end

	ppm_ram #(.W(56), .D(MAX_PEAKS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ppm_width u_width (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (state_q == B_MWID),
		.q         (cur_q_q),
		.out_valid (wu_valid),
		.w         (wu_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			cnt_q   <= '0;
			first_q <= 1'b0;
			rv_q    <= 1'b0;
		end else begin
			rv_q <= rv_set;
			unique case (state_q)
				B_IDLE: if (q_valid) begin
					first_q <= 1'b1;
					case (q_item.kind)
						KIND_OUT: ;
						KIND_DUMP: if (cnt_q != '0) state_q <= B_DRD;
						default: state_q <= (cnt_q == '0) ? B_END : B_SRD;
					endcase
				end
				B_SRD: state_q <= B_SCHK;
				B_SCHK: if (hit) begin
					state_q <= B_MERGE;
				end else if (scan_last) begin
					state_q <= B_END;
				end else begin
					state_q <= B_SRD;
				end
				B_MERGE: state_q <= (cfg.gain != 16'd0) ? B_MWID : B_MWR;
				B_MWID:  state_q <= B_MWAIT;
				B_MWAIT: if (wu_valid) state_q <= B_MWR;
				B_MWR: begin
					first_q <= 1'b0;
					// absorbed entry not at the end: move the last entry into its slot
					if (!first_q && other_q != last_ix && idx_q != other_q) begin
						state_q <= B_MVRD;
					end else begin
						state_q <= B_SRD;
						if (!first_q) cnt_q <= cnt_m1;
					end
				end
				B_MVRD: state_q <= B_MVWR;
				B_MVWR: begin
					cnt_q   <= cnt_m1;
					state_q <= B_SRD;
				end
				B_END: begin
					state_q <= B_IDLE;
					if (first_q && !table_full) cnt_q <= cnt_p1;
				end
				B_DRD: state_q <= B_DOUT;
				B_DOUT: begin
					if (scan_last) begin
						cnt_q   <= '0;
						state_q <= B_IDLE;
					end else begin
						state_q <= B_DRD;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: if (q_valid) begin
				it_q   <= q_item;
				scan_q <= '0;
				pt_q   <= 16'd0;
				pq_q   <= 24'd0;
				pw_q   <= 16'd0;
				last_q <= 1'b1;
				if (q_item.kind == KIND_OUT) begin
					st_q <= ST_OUTSIDE;
					pc_q <= cnt_q;
				end else begin
					st_q <= ST_EMPTY;
					pc_q <= '0;
				end
			end
			B_SCHK: if (hit) begin
				if (first_q) begin
					idx_q  <= scan_q;
					ma_t_q <= rd_t;
					ma_q_q <= rd_q;
					ma_w_q <= rd_w;
					mb_t_q <= it_q.t;
					mb_q_q <= it_q.q;
				end else if (idx_q == last_ix) begin
					// grown peak is the last entry: it is absorbed into the other one
					idx_q   <= scan_q;
					other_q <= scan_q;
					ma_t_q  <= rd_t;
					ma_q_q  <= rd_q;
					ma_w_q  <= rd_w;
					mb_t_q  <= cur_t_q;
					mb_q_q  <= cur_q_q;
				end else begin
					other_q <= scan_q;
					ma_t_q  <= cur_t_q;
					ma_q_q  <= cur_q_q;
					ma_w_q  <= cur_w_q;
					mb_t_q  <= rd_t;
					mb_q_q  <= rd_q;
				end
			end else if (!scan_last) begin
				scan_q <= scan_q + IDX_W'(1);
			end
			B_MERGE: begin
				cur_t_q <= (mb_t_q > ma_t_q) ? mb_t_q : ma_t_q;
				cur_q_q <= sat_add24(ma_q_q, mb_q_q);
				cur_w_q <= ma_w_q;
			end
			B_MWAIT: if (wu_valid) cur_w_q <= wu_w;
			B_MWR:   scan_q <= '0;
			B_MVWR:  scan_q <= '0;
			B_END: begin
				last_q <= 1'b1;
				if (first_q) begin
					pt_q <= it_q.t;
					pq_q <= it_q.q;
					pw_q <= it_q.w;
					if (table_full) begin
						st_q <= ST_FULL;
						pc_q <= cnt_q;
					end else begin
						st_q <= ST_NEW;
						pc_q <= cnt_p1;
					end
				end else begin
					st_q <= ST_MERGED;
					pt_q <= cur_t_q;
					pq_q <= cur_q_q;
					pw_q <= cur_w_q;
					pc_q <= cnt_q;
				end
			end
			B_DOUT: begin
				st_q   <= ST_DUMP;
				pt_q   <= rd_t;
				pq_q   <= rd_q;
				pw_q   <= rd_w;
				pc_q   <= '0;
				last_q <= scan_last;
				if (!scan_last) scan_q <= scan_q + IDX_W'(1);
			end
			default: ;
		endcase
	end

	assign result_valid = rv_q;
	assign status       = st_q;
	assign peak_time    = pt_q;
	assign peak_charge  = pq_q;
	assign peak_width   = pw_q;
	assign peak_count   = 5'(pc_q);
	assign last         = last_q;
endmodule

[hdl/ppm_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ppm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       result_valid,
	input logic [2:0] status,
	input logic [4:0] peak_count,
	input logic       last
);
	import ppm_pkg::*;

	`PPM_ASSERT_IMPL(a_single_last, clk, arst_n, result_valid && status != ST_DUMP, last, "single result not marked last")
	`PPM_ASSERT_IMPL(a_dump_count, clk, arst_n, result_valid && (status == ST_DUMP || status == ST_EMPTY), peak_count == 5'd0, "dump result with nonzero count")
	`PPM_ASSERT_IMPL(a_new_count, clk, arst_n, result_valid && (status == ST_NEW || status == ST_MERGED), peak_count != 5'd0, "peak result with empty table")
	`PPM_ASSERT_NEXT(a_dump_gap, clk, arst_n, result_valid && status == ST_DUMP && !last, !result_valid, "dump entries back to back")
endmodule

bind pulse_pileup_merge_table ppm_checker u_ppm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.status       (status),
	.peak_count   (peak_count),
	.last         (last)
);

[bench/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
	import ppm_pkg::*;

	localparam int PEAKS = DEF_MAX_PEAKS;

	typedef struct packed {
		logic [2:0]  st;
		logic [15:0] t;
		logic [23:0] q;
		logic [15:0] w;
		logic [4:0]  cnt;
		logic        lst;
	} peak_res_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        cmd;
	logic [15:0] hit_time;
	logic [23:0] hit_light;
	logic        cfg_we;
	logic [2:0]  cfg_addr;
	logic [23:0] cfg_wdata;
	logic        result_valid;
	logic [2:0]  status;
	logic [15:0] peak_time;
	logic [23:0] peak_charge;
	logic [15:0] peak_width;
	logic [4:0]  peak_count;
	logic        last;

	pulse_pileup_merge_table dut (.*);

	// shadow of the block's registers and peak table
	logic        m_sat_en;
	logic [15:0] m_coeff;
	logic [15:0] m_gain;
	logic [15:0] m_ped;
	logic [23:0] m_qmin;
	logic [15:0] m_tmin;
	logic [15:0] m_tmax;
	logic [15:0] tbl_t [PEAKS];
	logic [23:0] tbl_q [PEAKS];
	logic [15:0] tbl_w [PEAKS];
	int          tbl_n;

	peak_res_t expected_peaks[$];
	int        errors;
	int        n_requests;
	int        n_results;
	int        n_merges;
	int        n_full;
	int        idle_cycles;
	bit        burst_mode;
	int        burst_left;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic void add_expected(input peak_res_t r);
		expected_peaks.insert(expected_peaks.size(), r);
	endfunction

	function automatic logic [15:0] width_of(input logic [23:0] q);
		logic [63:0] w;
		if (q > m_qmin)
			w = ((64'(q) * m_gain) >> 12) + m_ped;
		else
			w = (64'(q) * m_gain * (64'(m_ped) + 64'd16)) >> 16;
		return (w > 64'hFFFF) ? 16'hFFFF : w[15:0];
	endfunction

	function automatic bit touches(input logic [15:0] ta, input logic [15:0] wa,
		input logic [15:0] tb, input logic [15:0] wb);
		return !((17'(ta) > 17'(tb) + 17'(wb)) || (17'(tb) > 17'(ta) + 17'(wa)));
	endfunction

	function automatic void absorb(input int d, input logic [15:0] t, input logic [23:0] q);
		logic [24:0] s;
		if (t > tbl_t[d])
			tbl_t[d] = t;
		s = 25'(tbl_q[d]) + 25'(q);
		tbl_q[d] = s[24] ? 24'hFFFFFF : s[23:0];
		if (m_gain != 16'd0)
			tbl_w[d] = width_of(tbl_q[d]);
	endfunction

	function automatic void predict_peaks(input logic c, input logic [15:0] t,
		input logic [23:0] light);
		logic [23:0] q;
		logic [15:0] w;
		logic [63:0] den;
		int          idx;
		int          other;
		int          tmp;
		bit          found;
		if (c) begin
			if (tbl_n == 0)
				add_expected({ST_EMPTY, 16'd0, 24'd0, 16'd0, 5'd0, 1'b1});
			for (int i = 0; i < tbl_n; i++)
				add_expected({ST_DUMP, tbl_t[i], tbl_q[i], tbl_w[i], 5'd0,
					1'(i == tbl_n - 1)});
			tbl_n = 0;
			return;
		end
		if (t < m_tmin || t > m_tmax) begin
			add_expected({ST_OUTSIDE, 16'd0, 24'd0, 16'd0, 5'(tbl_n), 1'b1});
			return;
		end
		if (m_sat_en) begin
			den = (64'd1 << 24) + 64'(m_coeff) * light;
			q = 24'((64'(light) << 24) / den);
		end else begin
			q = light;
		end
		w = width_of(q);
		found = 0;
		idx = 0;
		for (int i = 0; i < tbl_n && !found; i++)
			if (touches(tbl_t[i], tbl_w[i], t, w)) begin
				idx = i;
				found = 1;
			end
		if (!found) begin
			if (tbl_n >= PEAKS) begin
				n_full++;
				add_expected({ST_FULL, t, q, w, 5'(tbl_n), 1'b1});
				return;
			end
			tbl_t[tbl_n] = t;
			tbl_q[tbl_n] = q;
			tbl_w[tbl_n] = w;
			tbl_n++;
			add_expected({ST_NEW, t, q, w, 5'(tbl_n), 1'b1});
			return;
		end
		n_merges++;
		absorb(idx, t, q);
		forever begin
			found = 0;
			other = 0;
			for (int i = 0; i < tbl_n && !found; i++)
				if (i != idx && touches(tbl_t[i], tbl_w[i], tbl_t[idx], tbl_w[idx])) begin
					other = i;
					found = 1;
				end
			if (!found)
				break;
			if (idx == tbl_n - 1) begin
				tmp = idx;
				idx = other;
				other = tmp;
			end
			absorb(idx, tbl_t[other], tbl_q[other]);
			// last entry moves into the hole
			tbl_t[other] = tbl_t[tbl_n - 1];
			tbl_q[other] = tbl_q[tbl_n - 1];
			tbl_w[other] = tbl_w[tbl_n - 1];
			tbl_n--;
		end
		add_expected({ST_MERGED, tbl_t[idx], tbl_q[idx], tbl_w[idx],
			5'(tbl_n), 1'b1});
	endfunction

	task automatic report_mismatch(input string what, input logic [23:0] got,
		input logic [23:0] want);
		errors++;
		$display("mismatch %s: got %0d expected %0d", what, got, want);
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			n_results++;
			if (expected_peaks.size() == 0) begin
				errors++;
				$display("unexpected result status %0d", status);
			end else begin
				peak_res_t e;
				e = expected_peaks.pop_front();
				if (status !== e.st) report_mismatch("status", 24'(status), 24'(e.st));
				if (peak_time !== e.t) report_mismatch("peak_time", 24'(peak_time), 24'(e.t));
				if (peak_charge !== e.q) report_mismatch("peak_charge", peak_charge, e.q);
				if (peak_width !== e.w) report_mismatch("peak_width", 24'(peak_width), 24'(e.w));
				if (peak_count !== e.cnt) report_mismatch("peak_count", 24'(peak_count), 24'(e.cnt));
				if (last !== e.lst) report_mismatch("last", 24'(last), 24'(e.lst));
			end
		end
	end

	// watchdog on cycles with no accepted request or result
	always @(posedge clk) begin
		if ((start && !busy) || result_valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] a, input logic [23:0] d);
		cfg_we <= 1'b1;
		cfg_addr <= a;
		cfg_wdata <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (a)
			REG_SAT_EN:     m_sat_en = d[0];
			REG_SAT_COEFF:  m_coeff = d[15:0];
			REG_GAIN:       m_gain = d[15:0];
			REG_PEDESTAL:   m_ped = d[15:0];
			REG_CHARGE_MIN: m_qmin = d;
			REG_TIME_MIN:   m_tmin = d[15:0];
			REG_TIME_MAX:   m_tmax = d[15:0];
			default: ;
		endcase
	endtask

	task automatic drain;
		while (expected_peaks.size() != 0)
			@(posedge clk);
		// hits with no pending work still occupy the sequencer for a while
		repeat (200) @(posedge clk);
	endtask

	task automatic send_request(input logic c, input logic [15:0] t, input logic [23:0] l,
		input bit gaps);
		if (gaps) begin
			if (burst_left == 0) begin
				repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 60) : $urandom_range(0, 4))
					@(posedge clk);
				burst_left = $urandom_range(1, 10);
			end
			burst_left--;
		end
		start <= 1'b1;
		cmd <= c;
		hit_time <= t;
		hit_light <= l;
		// busy is sampled as it was before the edge, so this is the accepting edge
		@(posedge clk iff !busy);
		predict_peaks(c, t, l);
		n_requests++;
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_edges;
		send_request(1'b1, 16'd0, 24'd0, 0);
		send_request(1'b0, 16'd15, 24'd100, 0);
		send_request(1'b0, 16'd16001, 24'd100, 0);
		send_request(1'b0, 16'd16, 24'd0, 0);
		send_request(1'b0, 16'd16000, 24'hFFFFFF, 0);
		send_request(1'b0, 16'd100, 24'd172, 0);
		send_request(1'b0, 16'd100, 24'd173, 0);
		send_request(1'b0, 16'd5000, 24'd1, 0);
		send_request(1'b1, 16'hFFFF, 24'hFFFFFF, 0);
		drain();
		write_reg(REG_TIME_MIN, 24'd0);
		write_reg(REG_TIME_MAX, 24'hFFFF);
		write_reg(REG_SAT_EN, 24'd0);
		send_request(1'b0, 16'hFFFF, 24'hFFFFFF, 0);
		send_request(1'b0, 16'd0, 24'hFFFFFF, 0);
		send_request(1'b1, 16'd0, 24'd0, 0);
		drain();
	endtask

	// fill to capacity with spaced peaks, then overflow, then bridge them
	task automatic test_full_and_chain;
		write_reg(REG_GAIN, 24'd0);
		write_reg(REG_PEDESTAL, 24'd0);
		for (int i = 0; i < PEAKS; i++)
			send_request(1'b0, 16'(i * 100), 24'd50, 0);
		send_request(1'b0, 16'd5000, 24'd50, 0);
		drain();
		write_reg(REG_PEDESTAL, 24'hFFFF);
		write_reg(REG_GAIN, 24'hFFFF);
		write_reg(REG_CHARGE_MIN, 24'd0);
		send_request(1'b0, 16'd750, 24'hFFFFFF, 0);
		send_request(1'b1, 16'd0, 24'd0, 0);
		drain();
	endtask

	task automatic test_random(input int count);
		int kind;
		for (int i = 0; i < count; i++) begin
			if (i % 60 == 0) begin
				drain();
				write_reg(REG_SAT_EN, 24'($urandom_range(0, 1)));
				write_reg(REG_SAT_COEFF, 24'($urandom_range(0, 2) == 0 ? 16'hFFFF : $urandom_range(0, 2000)));
				write_reg(REG_GAIN, 24'($urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 600)));
				write_reg(REG_PEDESTAL, 24'($urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 400)));
				write_reg(REG_CHARGE_MIN, 24'($urandom_range(0, 3) == 0 ? $urandom_range(0, 24'hFFFFFF) : $urandom_range(0, 3000)));
				write_reg(REG_TIME_MIN, 24'($urandom_range(0, 200)));
				write_reg(REG_TIME_MAX, 24'($urandom_range(0, 3) == 0 ? 16'hFFFF : $urandom_range(3000, 65535)));
			end
			if (i == 130)
				drain();
			kind = $urandom_range(0, 19);
			if (kind == 0)
				send_request(1'b1, 16'($urandom), 24'($urandom), 1);
			else if (kind == 1)
				send_request(1'b0, 16'($urandom), 24'($urandom), 1);
			else
				send_request(1'b0, 16'($urandom_range(m_tmin, m_tmin + 4000 > 65535 ? 65535 : m_tmin + 4000)),
					24'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40000)), 1);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = 1'b0;
		hit_time = '0;
		hit_light = '0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		errors = 0;
		n_requests = 0;
		n_results = 0;
		n_merges = 0;
		n_full = 0;
		idle_cycles = 0;
		burst_left = 0;
		tbl_n = 0;
		m_sat_en = RST_SAT_EN;
		m_coeff = RST_SAT_COEFF;
		m_gain = RST_GAIN;
		m_ped = RST_PEDESTAL;
		m_qmin = RST_CHARGE_MIN;
		m_tmin = RST_TIME_MIN;
		m_tmax = RST_TIME_MAX;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edges();
		test_full_and_chain();
		test_random(200);
		send_request(1'b1, 16'd0, 24'd0, 0);
		drain();
		$display("covered %0d requests, %0d results, %0d merges, %0d table-full drops",
			n_requests, n_results, n_merges, n_full);
		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end
endmodule
